FILE: rtl/core/ffa_pkg.sv
package ffa_pkg;

	// Heap geometry: one store entry per 4-byte granule.
	localparam int unsigned HEAP_BYTES  = 16384;
	localparam int unsigned ALIGN_BYTES = 4;
	localparam int unsigned DEPTH       = HEAP_BYTES / ALIGN_BYTES;
	localparam int unsigned IDX_W       = $clog2(DEPTH);
	localparam int unsigned PTR_W       = IDX_W + 1;
	localparam int unsigned SIZE_W      = 15;

	localparam logic [PTR_W-1:0]  NIL            = PTR_W'(DEPTH);
	localparam logic [SIZE_W-1:0] HDR_BYTES      = SIZE_W'(8);
	localparam logic [SIZE_W-1:0] HEAP_MAX_BYTES = SIZE_W'(HEAP_BYTES);

	// Transaction modes.
	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE  = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_FIT   = 3'd1;
	localparam logic [2:0] ST_RANGE    = 3'd2;
	localparam logic [2:0] ST_NOT_USED = 3'd3;
	localparam logic [2:0] ST_UNUSABLE = 3'd4;

	// One header store entry.
	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [PTR_W-1:0]  nxt;
		logic              used;
		logic              start;
	} ffa_word_t;

	localparam int unsigned WORD_W = $bits(ffa_word_t);

endpackage

FILE: rtl/core/ffa_ram.sv
module ffa_ram #(
	parameter int unsigned WIDTH = 30,
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [WIDTH-1:0] wr_mask
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Bit-masked write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= (mem[wr_addr] & ~wr_mask) | (wr_data & wr_mask);
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/first_fit_heap_allocator_core.sv
// Channel     | Signals                                       | Handshake
// ------------+-----------------------------------------------+---------------------------
// command     | mode, request_bytes, address                  | start high, busy low
// result      | status, granted_address, free_bytes           | done strobe, one cycle
// config      | cfg_wr_data                                   | cfg_wr_en, written at once
//
// Allocate walks the free list up to the first node that fits; free walks the free nodes
// below the block; query walks every free node. The walk is set by the single read port
// of the header store. The first operation after reset or a config write that builds a
// usable heap also runs a clearing pass over all 4096 entries.
// Reset is asynchronous and active low; results cannot be stalled by the receiver.
module first_fit_heap_allocator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  mode,
	input  logic [ffa_pkg::SIZE_W-1:0]  request_bytes,
	input  logic [13:0]                 address,
	output logic                        done,
	output logic [2:0]                  status,
	output logic [13:0]                 granted_address,
	output logic [ffa_pkg::SIZE_W-1:0]  free_bytes,
	input  logic                        cfg_wr_en,
	input  logic [ffa_pkg::SIZE_W-1:0]  cfg_wr_data
);
	import ffa_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_CLEAR, S_INIT0, S_DISPATCH,
		S_A_RD, S_A_EV, S_A_WSPLIT, S_A_WPREV, S_A_WCUR,
		S_F_CHK, S_F_RD, S_F_EV, S_F_RDCUR, S_F_EVCUR, S_F_WBLK, S_F_WPREV, S_F_WCUR,
		S_Q_RD, S_Q_EV
	} state_t;

	state_t            state_q;
	logic [1:0]        mode_q;
	logic [SIZE_W-1:0] req_q;
	logic [13:0]       addr_q;
	logic [SIZE_W-1:0] heap_bytes_q;
	logic              ready_q;
	logic [SIZE_W-1:0] limit_q;
	logic [PTR_W-1:0]  head_q;
	logic [IDX_W-1:0]  clr_cnt_q;
	logic [PTR_W-1:0]  cur_q;
	logic [PTR_W-1:0]  prev_q;
	logic [PTR_W-1:0]  after_q;
	logic [PTR_W-1:0]  split_q;
	logic [SIZE_W-1:0] csize_q;
	logic [SIZE_W-1:0] remain_q;
	logic [SIZE_W-1:0] sb_q;
	logic [SIZE_W-1:0] sp_q;
	logic [PTR_W-1:0]  nb_q;
	logic              mn_q;
	logic              done_q;
	logic [2:0]        status_q;
	logic [13:0]       granted_q;
	logic [SIZE_W-1:0] free_q;

	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	ffa_word_t         wdat;
	ffa_word_t         wmsk;
	ffa_word_t         rw;

	logic [SIZE_W-1:0] init_sel;
	logic [SIZE_W-1:0] init_size;
	logic              init_small;
	logic [15:0]       need;
	logic              fits;
	logic [SIZE_W-1:0] remain;
	logic [PTR_W-1:0]  split;
	logic [13:0]       boff;
	logic [IDX_W-1:0]  blk;
	logic              range_bad;
	logic              align_bad;
	logic              adj_next;
	logic              mp;

	ffa_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wdat),
		.wr_mask (wmsk)
	);

	assign rw = rd_data;

	// Heap size for initialization: default on zero, saturate, align down.
	always_comb begin
		init_sel = (heap_bytes_q == '0) ? HEAP_MAX_BYTES : heap_bytes_q;
		if (init_sel > HEAP_MAX_BYTES) begin
			init_sel = HEAP_MAX_BYTES;
		end
		init_size  = {init_sel[SIZE_W-1:2], 2'b00};
		init_small = (init_size <= HDR_BYTES);
	end

	// Allocation arithmetic on the entry just read.
	always_comb begin
		need   = ({1'b0, req_q} + 16'd11) & 16'hFFFC;
		fits   = ({1'b0, rw.size} >= need);
		remain = rw.size - need[SIZE_W-1:0];
		split  = cur_q + need[PTR_W+1:2];
	end

	// Free checks and neighbor adjacency.
	always_comb begin
		boff      = addr_q - 14'd8;
		blk       = boff[13:2];
		range_bad = (addr_q < 14'd8) || ({1'b0, addr_q} >= limit_q);
		align_bad = (boff[1:0] != 2'b00);
		adj_next  = ({2'b00, blk, 2'b00} + {1'b0, sb_q}) == {2'b00, cur_q[IDX_W-1:0], 2'b00};
		mp        = (prev_q != NIL) &&
			(({2'b00, prev_q[IDX_W-1:0], 2'b00} + {1'b0, sp_q}) == {2'b00, blk, 2'b00});
	end

	// Store port control per state.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = cur_q[IDX_W-1:0];
		wdat    = '0;
		wmsk    = '0;
		unique case (state_q)
			S_CLEAR: begin
				wr_en      = 1'b1;
				wr_addr    = clr_cnt_q;
				wmsk.used  = 1'b1;
				wmsk.start = 1'b1;
			end
			S_INIT0: begin
				wr_en      = 1'b1;
				wr_addr    = '0;
				wdat.size  = init_size;
				wdat.nxt   = NIL;
				wdat.start = 1'b1;
				wmsk       = '1;
			end
			S_DISPATCH: begin
				rd_en   = (mode_q == MODE_FREE) && !range_bad && !align_bad;
				rd_addr = blk;
			end
			S_A_RD, S_F_RDCUR, S_Q_RD: begin
				rd_en = (cur_q != NIL);
			end
			S_F_RD: begin
				rd_en = (cur_q != NIL) && (cur_q < {1'b0, blk});
			end
			S_A_WSPLIT: begin
				wr_en      = 1'b1;
				wr_addr    = split_q[IDX_W-1:0];
				wdat.size  = remain_q;
				wdat.nxt   = after_q;
				wdat.start = 1'b1;
				wmsk       = '1;
			end
			S_A_WPREV: begin
				wr_en    = (prev_q != NIL);
				wr_addr  = prev_q[IDX_W-1:0];
				wdat.nxt = after_q;
				wmsk.nxt = '1;
			end
			S_A_WCUR: begin
				wr_en     = 1'b1;
				wdat.size = csize_q;
				wdat.nxt  = NIL;
				wdat.used = 1'b1;
				wmsk.size = '1;
				wmsk.nxt  = '1;
				wmsk.used = 1'b1;
			end
			S_F_WBLK: begin
				wr_en      = 1'b1;
				wr_addr    = blk;
				wdat.size  = sb_q;
				wdat.nxt   = nb_q;
				wdat.start = !mp;
				wmsk       = '1;
			end
			S_F_WPREV: begin
				wr_en     = (prev_q != NIL);
				wr_addr   = prev_q[IDX_W-1:0];
				wdat.size = mp ? (sp_q + sb_q) : sp_q;
				wdat.nxt  = mp ? nb_q : {1'b0, blk};
				wmsk.size = '1;
				wmsk.nxt  = '1;
			end
			S_F_WCUR: begin
				wr_en      = mn_q;
				wmsk.start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer: state, heap registers and the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			done_q       <= 1'b0;
			ready_q      <= 1'b0;
			limit_q      <= '0;
			head_q       <= NIL;
			heap_bytes_q <= HEAP_MAX_BYTES;
			clr_cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr_en) begin
				heap_bytes_q <= cfg_wr_data;
				ready_q      <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q    <= mode;
						req_q     <= request_bytes;
						addr_q    <= address;
						granted_q <= '0;
						free_q    <= '0;
						if ((mode != MODE_ALLOC && mode != MODE_FREE && mode != MODE_QUERY) ||
							(mode == MODE_FREE && address == '0)) begin
							status_q <= ST_OK;
							done_q   <= 1'b1;
						end else if (mode == MODE_ALLOC && request_bytes == '0) begin
							status_q <= ST_NO_FIT;
							done_q   <= 1'b1;
						end else if (!ready_q) begin
							if (init_small) begin
								limit_q  <= '0;
								head_q   <= NIL;
								status_q <= ST_UNUSABLE;
								done_q   <= 1'b1;
							end else begin
								clr_cnt_q <= '0;
								state_q   <= S_CLEAR;
							end
						end else begin
							state_q <= S_DISPATCH;
						end
					end
				end
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == '1) begin
						state_q <= S_INIT0;
					end
				end
				S_INIT0: begin
					head_q  <= '0;
					limit_q <= init_size;
					ready_q <= 1'b1;
					state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					prev_q <= NIL;
					cur_q  <= head_q;
					sb_q   <= '0;
					free_q <= '0;
					unique case (mode_q)
						MODE_ALLOC: state_q <= S_A_RD;
						MODE_FREE: begin
							if (range_bad) begin
								status_q <= ST_RANGE;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else if (align_bad) begin
								status_q <= ST_NOT_USED;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								state_q <= S_F_CHK;
							end
						end
						default: state_q <= S_Q_RD;
					endcase
				end
				S_A_RD: begin
					if (cur_q == NIL) begin
						status_q <= ST_NO_FIT;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_A_EV;
					end
				end
				S_A_EV: begin
					if (fits) begin
						after_q <= rw.nxt;
						csize_q <= rw.size;
						if (remain > HDR_BYTES) begin
							split_q  <= split;
							remain_q <= remain;
							state_q  <= S_A_WSPLIT;
						end else begin
							state_q <= S_A_WPREV;
						end
					end else begin
						prev_q  <= cur_q;
						cur_q   <= rw.nxt;
						state_q <= S_A_RD;
					end
				end
				S_A_WSPLIT: begin
					after_q <= split_q;
					csize_q <= need[SIZE_W-1:0];
					state_q <= S_A_WPREV;
				end
				S_A_WPREV: begin
					if (prev_q == NIL) begin
						head_q <= after_q;
					end
					state_q <= S_A_WCUR;
				end
				S_A_WCUR: begin
					status_q  <= ST_OK;
					granted_q <= {cur_q[IDX_W-1:0], 2'b00} + 14'd8;
					done_q    <= 1'b1;
					state_q   <= S_IDLE;
				end
				S_F_CHK: begin
					if (!rw.start || !rw.used) begin
						status_q <= ST_NOT_USED;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						sb_q    <= rw.size;
						state_q <= S_F_RD;
					end
				end
				S_F_RD: begin
					if (cur_q != NIL && cur_q < {1'b0, blk}) begin
						state_q <= S_F_EV;
					end else begin
						state_q <= S_F_RDCUR;
					end
				end
				S_F_EV: begin
					sp_q    <= rw.size;
					prev_q  <= cur_q;
					cur_q   <= rw.nxt;
					state_q <= S_F_RD;
				end
				S_F_RDCUR: begin
					nb_q <= cur_q;
					mn_q <= 1'b0;
					state_q <= (cur_q == NIL) ? S_F_WBLK : S_F_EVCUR;
				end
				S_F_EVCUR: begin
					if (adj_next) begin
						sb_q <= sb_q + rw.size;
						nb_q <= rw.nxt;
						mn_q <= 1'b1;
					end
					state_q <= S_F_WBLK;
				end
				S_F_WBLK: begin
					if (prev_q == NIL) begin
						head_q <= {1'b0, blk};
					end
					state_q <= S_F_WPREV;
				end
				S_F_WPREV: begin
					state_q <= S_F_WCUR;
				end
				S_F_WCUR: begin
					status_q <= ST_OK;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_Q_RD: begin
					if (cur_q == NIL) begin
						status_q <= ST_OK;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_Q_EV;
					end
				end
				S_Q_EV: begin
					free_q  <= free_q + rw.size;
					cur_q   <= rw.nxt;
					state_q <= S_Q_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign status          = status_q;
	assign granted_address = granted_q;
	assign free_bytes      = free_q;

	// A result is only presented once the sequencer has returned to idle.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while sequencer busy");

	// The store is never read and written in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n) !(rd_en && wr_en))
		else $error("store read and write collide");

	// A granted address is reported only with a good status.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && granted_address != '0) |-> (status == ST_OK))
		else $error("granted address with failing status");

	// The clearing pass ends by writing the first free block.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && clr_cnt_q == '1) |=> (state_q == S_INIT0))
		else $error("clearing pass did not end in heap setup");

endmodule

FILE: tb/tb_first_fit_heap_allocator_core.sv
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator_core;
	import ffa_pkg::*;

	localparam logic [1:0] MODE_UNKNOWN = 2'd3;
	localparam int unsigned GRANULES = HEAP_BYTES / ALIGN_BYTES;
	localparam int unsigned NO_BLOCK = GRANULES;
	localparam int unsigned HEADER = 8;
	localparam longint unsigned CYCLE_LIMIT = 8_000_000;

	typedef struct packed {
		logic [2:0]        status;
		logic [13:0]       granted;
		logic [SIZE_W-1:0] free_total;
	} heap_answer_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        mode = MODE_ALLOC;
	logic [SIZE_W-1:0] request_bytes = '0;
	logic [13:0]       address = '0;
	logic              done;
	logic [2:0]        status;
	logic [13:0]       granted_address;
	logic [SIZE_W-1:0] free_bytes;
	logic              cfg_wr_en = 1'b0;
	logic [SIZE_W-1:0] cfg_wr_data = '0;

	// Mirror of the allocator state, indexed by granule.
	int unsigned blk_size [GRANULES];
	bit          blk_used [GRANULES];
	bit          blk_start [GRANULES];
	int unsigned blk_next [GRANULES];
	int unsigned free_list_head = NO_BLOCK;
	int unsigned heap_end = 0;
	bit          heap_built = 1'b0;
	int unsigned heap_cfg = 16384;

	heap_answer_t    pending_answers[$];
	int unsigned     live_blocks[$];
	int unsigned     sender_idle_pct = 0;
	bit              failed = 1'b0;
	longint unsigned cycle_count = 0;

	first_fit_heap_allocator_core i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.mode            (mode),
		.request_bytes   (request_bytes),
		.address         (address),
		.done            (done),
		.status          (status),
		.granted_address (granted_address),
		.free_bytes      (free_bytes),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data)
	);

	always #5 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Rebuild the heap as one free block of the configured size; a size of a header or less leaves it unbuilt.
	function automatic void build_heap();
		int unsigned sz;
		sz = (heap_cfg == 0) ? HEAP_BYTES : heap_cfg;
		if (sz > HEAP_BYTES)
			sz = HEAP_BYTES;
		sz = (sz / ALIGN_BYTES) * ALIGN_BYTES;
		foreach (blk_used[i]) begin
			blk_used[i] = 1'b0;
			blk_start[i] = 1'b0;
		end
		if (sz <= HEADER) begin
			heap_end = 0;
			free_list_head = NO_BLOCK;
			heap_built = 1'b0;
			return;
		end
		heap_end = sz;
		free_list_head = 0;
		blk_size[0] = sz;
		blk_next[0] = NO_BLOCK;
		blk_start[0] = 1'b1;
		heap_built = 1'b1;
	endfunction

	// First-fit search with a split when more than a header would remain.
	function automatic bit take_first_fit(input int unsigned req, output int unsigned granted);
		int unsigned need, prev, cur, csize, remain, after, split;
		need = ((req + HEADER + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
		prev = NO_BLOCK;
		cur = free_list_head;
		granted = 0;
		while (cur < GRANULES) begin
			csize = blk_size[cur];
			if (csize >= need) begin
				remain = csize - need;
				after = blk_next[cur];
				if (remain > HEADER) begin
					split = cur + need / ALIGN_BYTES;
					if (split < GRANULES) begin
						blk_size[split] = remain;
						blk_next[split] = after;
						blk_used[split] = 1'b0;
						blk_start[split] = 1'b1;
					end
					after = split;
					csize = need;
				end
				if (prev == NO_BLOCK)
					free_list_head = after;
				else
					blk_next[prev] = after;
				blk_size[cur] = csize;
				blk_used[cur] = 1'b1;
				blk_next[cur] = NO_BLOCK;
				granted = cur * ALIGN_BYTES + HEADER;
				return 1'b1;
			end
			prev = cur;
			cur = blk_next[cur];
		end
		return 1'b0;
	endfunction

	// Address-ordered reinsertion, merging with both neighbors.
	function automatic void return_block(input int unsigned blk);
		int unsigned prev, cur;
		prev = NO_BLOCK;
		cur = free_list_head;
		while (cur < GRANULES && cur < blk) begin
			prev = cur;
			cur = blk_next[cur];
		end
		blk_next[blk] = cur;
		if (prev == NO_BLOCK)
			free_list_head = blk;
		else
			blk_next[prev] = blk;
		if (cur < GRANULES && blk * ALIGN_BYTES + blk_size[blk] == cur * ALIGN_BYTES) begin
			blk_size[blk] = blk_size[blk] + blk_size[cur];
			blk_next[blk] = blk_next[cur];
			blk_start[cur] = 1'b0;
		end
		if (prev < GRANULES && prev * ALIGN_BYTES + blk_size[prev] == blk * ALIGN_BYTES) begin
			blk_size[prev] = blk_size[prev] + blk_size[blk];
			blk_next[prev] = blk_next[blk];
			blk_start[blk] = 1'b0;
		end
	endfunction

	// Expected answer of one transaction; also tracks live blocks.
	function automatic heap_answer_t predict_heap_op(input logic [1:0] m,
			input int unsigned req, input int unsigned addr);
		heap_answer_t ans;
		int unsigned granted, boff, blk, cur;
		int unsigned total;
		ans = '0;
		total = 0;
		if (m == MODE_ALLOC) begin
			if (req == 0) begin
				ans.status = ST_NO_FIT;
			end else begin
				if (!heap_built)
					build_heap();
				if (!heap_built)
					ans.status = ST_UNUSABLE;
				else if (take_first_fit(req, granted)) begin
					ans.granted = granted[13:0];
					live_blocks.push_back(granted);
				end else
					ans.status = ST_NO_FIT;
			end
		end else if (m == MODE_FREE) begin
			if (addr != 0) begin
				if (!heap_built)
					build_heap();
				if (!heap_built)
					ans.status = ST_UNUSABLE;
				else if (addr < HEADER || addr >= heap_end)
					ans.status = ST_RANGE;
				else begin
					boff = addr - HEADER;
					blk = boff / ALIGN_BYTES;
					if (boff % ALIGN_BYTES != 0 || blk >= GRANULES || !blk_start[blk] ||
							!blk_used[blk])
						ans.status = ST_NOT_USED;
					else begin
						blk_used[blk] = 1'b0;
						return_block(blk);
						foreach (live_blocks[i])
							if (live_blocks[i] == addr) begin
								live_blocks.delete(i);
								break;
							end
					end
				end
			end
		end else if (m == MODE_QUERY) begin
			if (!heap_built)
				build_heap();
			if (!heap_built)
				ans.status = ST_UNUSABLE;
			else begin
				cur = free_list_head;
				while (cur < GRANULES) begin
					total += blk_size[cur];
					cur = blk_next[cur];
				end
			end
		end
		ans.free_total = total[SIZE_W-1:0];
		return ans;
	endfunction

	// Result checker: every strobe must match the oldest expected answer.
	always @(posedge clk) begin
		heap_answer_t exp_ans;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				$error("unexpected result: status %0d granted %0d free %0d",
					status, granted_address, free_bytes);
				failed = 1'b1;
			end else begin
				exp_ans = pending_answers.pop_front();
				if (status !== exp_ans.status) begin
					$error("status: expected %0d, got %0d", exp_ans.status, status);
					failed = 1'b1;
				end
				if (granted_address !== exp_ans.granted) begin
					$error("granted_address: expected %0d, got %0d",
						exp_ans.granted, granted_address);
					failed = 1'b1;
				end
				if (free_bytes !== exp_ans.free_total) begin
					$error("free_bytes: expected %0d, got %0d", exp_ans.free_total, free_bytes);
					failed = 1'b1;
				end
			end
		end
	end

	// Send one transaction, with an optional idle gap in front of it.
	task automatic send_heap_op(input logic [1:0] m, input int unsigned req,
			input int unsigned addr);
		if ($urandom_range(99) < sender_idle_pct)
			repeat ($urandom_range(1, 8)) @(posedge clk);
		@(posedge clk);
		start <= 1'b1;
		mode <= m;
		request_bytes <= req[SIZE_W-1:0];
		address <= addr[13:0];
		do
			@(posedge clk);
		while (busy);
		pending_answers.push_back(predict_heap_op(m, req, addr));
		start <= 1'b0;
	endtask

	// Write the size register once the block has drained.
	task automatic write_size_reg(input int unsigned sz);
		wait (pending_answers.size() == 0);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= sz[SIZE_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		heap_cfg = sz;
		heap_built = 1'b0;
		live_blocks.delete();
	endtask

	// Field extremes, bad frees, merging and the unknown mode on the default heap.
	task automatic test_basic_ops();
		send_heap_op(MODE_QUERY, 0, 0);
		send_heap_op(MODE_ALLOC, 1, 0);
		send_heap_op(MODE_ALLOC, 100, 0);
		send_heap_op(MODE_ALLOC, 32767, 0);
		send_heap_op(MODE_ALLOC, 0, 0);
		send_heap_op(MODE_FREE, 0, 0);
		send_heap_op(MODE_FREE, 0, 4);
		send_heap_op(MODE_FREE, 0, 10);
		send_heap_op(MODE_FREE, 0, 12);
		send_heap_op(MODE_FREE, 0, 16383);
		send_heap_op(MODE_FREE, 0, 8);
		send_heap_op(MODE_FREE, 0, 8);
		send_heap_op(MODE_FREE, 0, 20);
		send_heap_op(MODE_UNKNOWN, 32767, 16383);
		send_heap_op(MODE_QUERY, 0, 0);
	endtask

	// Register extremes: too small, tiny, saturating and default sizes.
	task automatic test_heap_sizes();
		write_size_reg(8);
		send_heap_op(MODE_ALLOC, 4, 0);
		send_heap_op(MODE_FREE, 0, 8);
		send_heap_op(MODE_FREE, 0, 0);
		send_heap_op(MODE_QUERY, 0, 0);
		write_size_reg(15);
		send_heap_op(MODE_ALLOC, 4, 0);
		send_heap_op(MODE_ALLOC, 1, 0);
		send_heap_op(MODE_FREE, 0, 200);
		write_size_reg(32767);
		send_heap_op(MODE_ALLOC, 16376, 0);
		send_heap_op(MODE_QUERY, 0, 0);
		send_heap_op(MODE_FREE, 0, 8);
		write_size_reg(0);
		send_heap_op(MODE_QUERY, 0, 0);
	endtask

	// Mostly well-formed alloc/free traffic with some queries and noise.
	task automatic run_random_traffic(input int unsigned count);
		int unsigned pick, req;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				req = ($urandom_range(19) == 0) ? $urandom_range(1, 32767) :
					$urandom_range(1, 256);
				send_heap_op(MODE_ALLOC, req, $urandom_range(16383));
			end else if (pick < 80 && live_blocks.size() > 0)
				send_heap_op(MODE_FREE, $urandom_range(32767),
					live_blocks[$urandom_range(live_blocks.size() - 1)]);
			else if (pick < 88)
				send_heap_op(MODE_QUERY, $urandom_range(32767), $urandom_range(16383));
			else if (pick < 95)
				send_heap_op(MODE_FREE, 0, $urandom_range(16383));
			else if (pick < 98)
				send_heap_op(MODE_ALLOC, 0, 0);
			else
				send_heap_op(MODE_UNKNOWN, $urandom_range(32767), $urandom_range(16383));
		end
	endtask

	// Random traffic over several heap sizes and idle patterns.
	task automatic test_random_phases();
		sender_idle_pct = 16;
		write_size_reg(16384);
		run_random_traffic(330);
		sender_idle_pct = 71;
		write_size_reg(512);
		run_random_traffic(330);
		sender_idle_pct = 0;
		write_size_reg(0);
		run_random_traffic(340);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_basic_ops();
		test_heap_sizes();
		test_random_phases();
		wait (pending_answers.size() == 0);
		repeat (50) @(posedge clk);
		if (!failed)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
